// ===== rtl/core/bcs_pkg.sv =====
`default_nettype none
package bcs_pkg;

  localparam int unsigned NUM_CH = 3;

  // lane order inside the channel arrays
  localparam int unsigned CH_RED   = 0;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_BLUE  = 2;

  // register indexes on the configuration port
  localparam logic [1:0] REG_BRIGHTNESS = 2'd0;
  localparam logic [1:0] REG_CONTRAST   = 2'd1;
  localparam logic [1:0] REG_SATURATION = 2'd2;

  localparam int unsigned OFS_W  = 9;   // brightness offset, signed
  localparam int unsigned GAIN_W = 12;  // Q4.8 unsigned gains
  localparam int unsigned PIX_W  = 8;
  localparam int unsigned CEN_W  = 10;  // channel + offset - 128
  localparam int unsigned YQ_W   = 22;  // contrast result, Q.8
  localparam int unsigned LUMA_W = 38;  // luma, Q.24
  localparam int unsigned DIFF_W = 39;  // channel minus luma, Q.24
  localparam int unsigned Z_W    = 52;  // saturation result, Q.32

  localparam logic signed [CEN_W-1:0] MID_LEVEL = 10'sd128;
  localparam logic signed [YQ_W:0]    MID_Q8    = 23'sd32768;

  // Q0.16 luma weights, sum is exactly one
  localparam logic signed [17:0] LUMA_WR = 18'sd19595;
  localparam logic signed [17:0] LUMA_WG = 18'sd38470;
  localparam logic signed [17:0] LUMA_WB = 18'sd7471;

  typedef logic [PIX_W-1:0]          pix_t;
  typedef logic [GAIN_W-1:0]         gain_t;
  typedef logic signed [OFS_W-1:0]   ofs_t;
  typedef logic signed [CEN_W-1:0]   cen_t;
  typedef logic signed [YQ_W-1:0]    yq_t;
  typedef logic signed [LUMA_W-1:0]  luma_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [Z_W-1:0]     zq_t;

  // fields that ride along with each beat untouched
  typedef struct packed {
    logic [PIX_W-1:0] alpha;
    logic             frame_end;
  } side_t;

endpackage
`default_nettype wire

// ===== rtl/core/bcs_contrast.sv =====
`default_nettype none
module bcs_contrast (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire bcs_pkg::side_t side_i,
  input  wire bcs_pkg::pix_t  pix_i [bcs_pkg::NUM_CH],
  input  wire bcs_pkg::ofs_t  ofs_i,
  input  wire bcs_pkg::gain_t gain_i,
  output logic               valid_o,
  output bcs_pkg::side_t     side_o,
  output bcs_pkg::yq_t       y_o [bcs_pkg::NUM_CH]
);
  import bcs_pkg::*;

  logic  v1_q, v2_q;
  side_t s1_q, s2_q;
  cen_t  cen_d [NUM_CH];
  cen_t  cen_q [NUM_CH];
  yq_t   y_d   [NUM_CH];
  yq_t   y_q   [NUM_CH];
  logic signed [YQ_W:0] prod [NUM_CH];

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      cen_d[i] = $signed({2'b00, pix_i[i]}) + CEN_W'(ofs_i) - MID_LEVEL;
      prod[i]  = cen_q[i] * $signed({1'b0, gain_i});
      y_d[i]   = yq_t'(prod[i] + MID_Q8);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q  <= side_i;
    s2_q  <= s1_q;
    cen_q <= cen_d;
    y_q   <= y_d;
  end

  assign valid_o = v2_q;
  assign side_o  = s2_q;
  assign y_o     = y_q;

endmodule
`default_nettype wire

// ===== rtl/core/bcs_luma.sv =====
`default_nettype none
module bcs_luma (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire bcs_pkg::side_t side_i,
  input  wire bcs_pkg::yq_t   y_i [bcs_pkg::NUM_CH],
  output logic               valid_o,
  output bcs_pkg::side_t     side_o,
  output bcs_pkg::luma_t     luma_o,
  output bcs_pkg::diff_t     diff_o [bcs_pkg::NUM_CH]
);
  import bcs_pkg::*;

  logic  v3_q, v4_q, v5_q;
  side_t s3_q, s4_q, s5_q;
  logic signed [17:0] wgt [NUM_CH];
  logic signed [YQ_W+17:0] full [NUM_CH];
  luma_t p_d  [NUM_CH];
  luma_t p_q  [NUM_CH];
  yq_t   y3_q [NUM_CH];
  yq_t   y4_q [NUM_CH];
  luma_t luma_d, luma4_q, luma5_q;
  diff_t diff_d [NUM_CH];
  diff_t diff_q [NUM_CH];
  logic signed [YQ_W+15:0] yshift [NUM_CH];

  assign wgt[CH_RED]   = LUMA_WR;
  assign wgt[CH_GREEN] = LUMA_WG;
  assign wgt[CH_BLUE]  = LUMA_WB;

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      full[i]   = y_i[i] * wgt[i];
      p_d[i]    = $signed(full[i][LUMA_W-1:0]);
      yshift[i] = $signed({y4_q[i], 16'h0000});
      diff_d[i] = DIFF_W'(yshift[i]) - DIFF_W'(luma4_q);
    end
    luma_d = p_q[CH_RED] + p_q[CH_GREEN] + p_q[CH_BLUE];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v3_q <= valid_i;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_q    <= side_i;
    s4_q    <= s3_q;
    s5_q    <= s4_q;
    p_q     <= p_d;
    y3_q    <= y_i;
    y4_q    <= y3_q;
    luma4_q <= luma_d;
    luma5_q <= luma4_q;
    diff_q  <= diff_d;
  end

  assign valid_o = v5_q;
  assign side_o  = s5_q;
  assign luma_o  = luma5_q;
  assign diff_o  = diff_q;

endmodule
`default_nettype wire

// ===== rtl/core/bcs_saturate.sv =====
`default_nettype none
module bcs_saturate (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire bcs_pkg::side_t side_i,
  input  wire bcs_pkg::luma_t luma_i,
  input  wire bcs_pkg::diff_t diff_i [bcs_pkg::NUM_CH],
  input  wire bcs_pkg::gain_t gain_i,
  output logic               valid_o,
  output bcs_pkg::side_t     side_o,
  output bcs_pkg::pix_t      pix_o [bcs_pkg::NUM_CH]
);
  import bcs_pkg::*;

  logic  v6_q, v7_q;
  side_t s6_q, s7_q;
  zq_t   prod [NUM_CH];
  zq_t   z_d  [NUM_CH];
  zq_t   z_q  [NUM_CH];
  pix_t  pix_d [NUM_CH];
  pix_t  pix_q [NUM_CH];
  logic signed [LUMA_W+7:0] luma_sh;

  always_comb begin
    luma_sh = $signed({luma_i, 8'h00});
    for (int i = 0; i < NUM_CH; i++) begin
      prod[i] = diff_i[i] * $signed({1'b0, gain_i});
      z_d[i]  = prod[i] + Z_W'(luma_sh);
      // drop the fraction, clamp to the pixel range
      if (z_q[i][Z_W-1]) begin
        pix_d[i] = '0;
      end else if (|z_q[i][Z_W-2:40]) begin
        pix_d[i] = '1;
      end else begin
        pix_d[i] = z_q[i][39:32];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      v6_q <= valid_i;
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s6_q  <= side_i;
    s7_q  <= s6_q;
    z_q   <= z_d;
    pix_q <= pix_d;
  end

  assign valid_o = v7_q;
  assign side_o  = s7_q;
  assign pix_o   = pix_q;

endmodule
`default_nettype wire

// ===== rtl/core/rgb_brightness_contrast_saturation_top.sv =====
// A beat accepted on start shows on the outputs together with done_o after the clamp stage.
// Throughput: one pixel per cycle; busy is always low, seven register stages
// (offset, contrast multiply, luma weights, luma sum, difference, saturation
// multiply, clamp) each hold one beat.
// Reset: clears the stage valid bits and loads offset 0, contrast and saturation 1.0.
// The receiver cannot stall; results are presented for exactly one cycle.
`default_nettype none
module rgb_brightness_contrast_saturation_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  red_in_i,
  input  wire logic [7:0]  green_in_i,
  input  wire logic [7:0]  blue_in_i,
  input  wire logic [7:0]  alpha_in_i,
  input  wire logic        frame_end_in_i,
  output logic             done_o,
  output logic [7:0]       red_out_o,
  output logic [7:0]       green_out_o,
  output logic [7:0]       blue_out_o,
  output logic [7:0]       alpha_out_o,
  output logic             frame_end_out_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [11:0] cfg_data_i
);
  import bcs_pkg::*;

  ofs_t  ofs_q;
  gain_t contrast_q, saturation_q;

  pix_t  pix_in  [NUM_CH];
  pix_t  pix_out [NUM_CH];
  yq_t   y_w     [NUM_CH];
  diff_t diff_w  [NUM_CH];
  luma_t luma_w;
  side_t side_in, side_c, side_l, side_s;
  logic  in_valid, valid_c, valid_l, valid_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ofs_q        <= '0;
      contrast_q   <= GAIN_W'(256);
      saturation_q <= GAIN_W'(256);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BRIGHTNESS: ofs_q        <= $signed(cfg_data_i[OFS_W-1:0]);
        REG_CONTRAST:   contrast_q   <= cfg_data_i;
        REG_SATURATION: saturation_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy     = 1'b0;
  assign in_valid = start & ~busy;

  assign pix_in[CH_RED]    = red_in_i;
  assign pix_in[CH_GREEN]  = green_in_i;
  assign pix_in[CH_BLUE]   = blue_in_i;
  assign side_in.alpha     = alpha_in_i;
  assign side_in.frame_end = frame_end_in_i;

  bcs_contrast u_contrast (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid),
    .side_i  (side_in),
    .pix_i   (pix_in),
    .ofs_i   (ofs_q),
    .gain_i  (contrast_q),
    .valid_o (valid_c),
    .side_o  (side_c),
    .y_o     (y_w)
  );

  bcs_luma u_luma (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_c),
    .side_i  (side_c),
    .y_i     (y_w),
    .valid_o (valid_l),
    .side_o  (side_l),
    .luma_o  (luma_w),
    .diff_o  (diff_w)
  );

  bcs_saturate u_saturate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_l),
    .side_i  (side_l),
    .luma_i  (luma_w),
    .diff_i  (diff_w),
    .gain_i  (saturation_q),
    .valid_o (valid_s),
    .side_o  (side_s),
    .pix_o   (pix_out)
  );

  assign done_o          = valid_s;
  assign red_out_o       = pix_out[CH_RED];
  assign green_out_o     = pix_out[CH_GREEN];
  assign blue_out_o      = pix_out[CH_BLUE];
  assign alpha_out_o     = side_s.alpha;
  assign frame_end_out_o = side_s.frame_end;

endmodule
`default_nettype wire

// ===== test/rgb_brightness_contrast_saturation_top_test.sv =====
`default_nettype none
module rgb_brightness_contrast_saturation_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bcs_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;  // no register behind it
  localparam longint WEIGHT_RED   = 19595;
  localparam longint WEIGHT_GREEN = 38470;
  localparam longint WEIGHT_BLUE  = 7471;
  localparam int     IDLE_LIMIT   = 2000;
  localparam int     FLUSH_CYCLES = 20;

  typedef struct packed {
    pix_t red;
    pix_t green;
    pix_t blue;
    pix_t alpha;
    logic frame_end;
  } rgba_t;

  typedef enum logic [1:0] {OP_PIXEL, OP_CONFIG, OP_DRAIN} op_kind_e;

  typedef struct {
    op_kind_e    kind;
    rgba_t       pixel;
    logic [1:0]  idx;
    logic [11:0] data;
    int          gap;
  } stim_op_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [7:0]  red_in_i = '0;
  logic [7:0]  green_in_i = '0;
  logic [7:0]  blue_in_i = '0;
  logic [7:0]  alpha_in_i = '0;
  logic        frame_end_in_i = 1'b0;
  logic        done_o;
  logic [7:0]  red_out_o;
  logic [7:0]  green_out_o;
  logic [7:0]  blue_out_o;
  logic [7:0]  alpha_out_o;
  logic        frame_end_out_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [11:0] cfg_data_i = '0;

  rgb_brightness_contrast_saturation_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .red_in_i        (red_in_i),
    .green_in_i      (green_in_i),
    .blue_in_i       (blue_in_i),
    .alpha_in_i      (alpha_in_i),
    .frame_end_in_i  (frame_end_in_i),
    .done_o          (done_o),
    .red_out_o       (red_out_o),
    .green_out_o     (green_out_o),
    .blue_out_o      (blue_out_o),
    .alpha_out_o     (alpha_out_o),
    .frame_end_out_o (frame_end_out_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  stim_op_t pending_ops[$];
  rgba_t    expected_pixels[$];
  int       beats_sent = 0;
  int       results_seen = 0;
  int       mismatch_count = 0;

  // shadow of the adjust registers, owned by the driver
  ofs_t  brightness_q = '0;
  gain_t contrast_q = 12'd256;
  gain_t saturation_q = 12'd256;

  function automatic rgba_t adjust_pixel(rgba_t px, ofs_t ofs, gain_t con, gain_t sat);
    longint chan_q8 [NUM_CH];
    pix_t   chan_in [NUM_CH];
    pix_t   chan_out [NUM_CH];
    longint luma_q24;
    longint z;
    longint whole;
    rgba_t  res;
    chan_in[CH_RED]   = px.red;
    chan_in[CH_GREEN] = px.green;
    chan_in[CH_BLUE]  = px.blue;
    for (int k = 0; k < NUM_CH; k++) begin
      chan_q8[k] = (longint'(chan_in[k]) + longint'(ofs) - 128) * longint'(con) + 32768;
    end
    luma_q24 = WEIGHT_RED * chan_q8[CH_RED] + WEIGHT_GREEN * chan_q8[CH_GREEN]
             + WEIGHT_BLUE * chan_q8[CH_BLUE];
    for (int k = 0; k < NUM_CH; k++) begin
      z = luma_q24 * 256 + (chan_q8[k] * 65536 - luma_q24) * longint'(sat);
      if (z < 0) begin
        chan_out[k] = 8'd0;
      end else begin
        whole = z >>> 32;
        chan_out[k] = (whole > 255) ? 8'd255 : whole[7:0];
      end
    end
    res.red       = chan_out[CH_RED];
    res.green     = chan_out[CH_GREEN];
    res.blue      = chan_out[CH_BLUE];
    res.alpha     = px.alpha;
    res.frame_end = px.frame_end;
    return res;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("[%0t] %s mismatch: got %0d, expected %0d", $realtime, field, got, want);
    mismatch_count++;
  endtask

  // driver: one op from the queue at a time, config writes only when drained
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    logic     taken;
    logic     idle;
    logic     nxt_start;
    logic     nxt_we;
    stim_op_t op;
    static int gap_left = 0;
    if (!rst_ni) begin
      start    <= 1'b0;
      cfg_we_i <= 1'b0;
    end else begin
      taken     = start && !busy;
      nxt_start = start && busy;
      nxt_we    = 1'b0;
      if (taken) begin
        expected_pixels.push_back(adjust_pixel({red_in_i, green_in_i, blue_in_i,
                                                alpha_in_i, frame_end_in_i},
                                               brightness_q, contrast_q, saturation_q));
        beats_sent <= beats_sent + 1;
      end
      idle = !taken && !start && (beats_sent == results_seen);
      if (!nxt_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_ops.size() > 0) begin
          op = pending_ops[0];
          case (op.kind)
            OP_PIXEL: begin
              void'(pending_ops.pop_front());
              red_in_i       <= op.pixel.red;
              green_in_i     <= op.pixel.green;
              blue_in_i      <= op.pixel.blue;
              alpha_in_i     <= op.pixel.alpha;
              frame_end_in_i <= op.pixel.frame_end;
              nxt_start = 1'b1;
              gap_left  = op.gap;
            end
            OP_CONFIG: begin
              if (idle) begin
                void'(pending_ops.pop_front());
                cfg_idx_i  <= op.idx;
                cfg_data_i <= op.data;
                nxt_we = 1'b1;
                case (op.idx)
                  REG_BRIGHTNESS: brightness_q = op.data[OFS_W-1:0];
                  REG_CONTRAST:   contrast_q = op.data;
                  REG_SATURATION: saturation_q = op.data;
                  default: ;
                endcase
              end
            end
            default: begin
              if (idle) void'(pending_ops.pop_front());
            end
          endcase
        end
      end
      start    <= nxt_start;
      cfg_we_i <= nxt_we;
    end
  end

  always @(posedge clk_i) begin : monitor_proc
    rgba_t want;
    if (rst_ni && done_o) begin
      results_seen <= results_seen + 1;
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = expected_pixels.pop_front();
        if (red_out_o !== want.red) report_mismatch("red", red_out_o, want.red);
        if (green_out_o !== want.green) report_mismatch("green", green_out_o, want.green);
        if (blue_out_o !== want.blue) report_mismatch("blue", blue_out_o, want.blue);
        if (alpha_out_o !== want.alpha) report_mismatch("alpha", alpha_out_o, want.alpha);
        if (frame_end_out_o !== want.frame_end) begin
          report_mismatch("frame_end", frame_end_out_o, want.frame_end);
        end
      end
    end
  end

  // abort when neither side moves for too long
  always @(posedge clk_i) begin : watchdog_proc
    static int stuck = 0;
    if ((start && !busy) || done_o || cfg_we_i || !rst_ni) begin
      stuck = 0;
    end else begin
      stuck++;
      if (stuck >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic void add_pixel(pix_t r, pix_t g, pix_t b, pix_t a, logic fe, int gap);
    stim_op_t op;
    op.kind  = OP_PIXEL;
    op.pixel = '{red: r, green: g, blue: b, alpha: a, frame_end: fe};
    op.idx   = '0;
    op.data  = '0;
    op.gap   = gap;
    pending_ops.push_back(op);
  endfunction

  function automatic void add_config(logic [1:0] idx, logic [11:0] data);
    stim_op_t op;
    op.kind  = OP_CONFIG;
    op.pixel = '0;
    op.idx   = idx;
    op.data  = data;
    op.gap   = 0;
    pending_ops.push_back(op);
  endfunction

  function automatic void add_drain();
    stim_op_t op;
    op.kind  = OP_DRAIN;
    op.pixel = '0;
    op.idx   = '0;
    op.data  = '0;
    op.gap   = 0;
    pending_ops.push_back(op);
  endfunction

  function automatic pix_t rand_level();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return pix_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [11:0] rand_gain();
    case ($urandom_range(0, 5))
      0:       return 12'd0;
      1:       return 12'd4095;
      2:       return 12'd256;
      3:       return 12'($urandom_range(128, 512));
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  initial begin : stim_proc
    int   gap_style;
    int   gap;
    pix_t r;
    pix_t g;
    pix_t b;

    // reset values first: corners, primaries, gray, side fields
    add_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 0);
    add_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 0);
    add_pixel(8'd255, 8'd0, 8'd0, 8'hAA, 1'b0, 0);
    add_pixel(8'd0, 8'd255, 8'd0, 8'h55, 1'b1, 3);
    add_pixel(8'd0, 8'd0, 8'd255, 8'd1, 1'b0, 0);
    add_pixel(8'd128, 8'd128, 8'd128, 8'd128, 1'b0, 16);
    add_pixel(8'd127, 8'd129, 8'd1, 8'd254, 1'b1, 0);
    // darkest offset with data bits above the register, full gains: heavy clamping
    add_config(REG_BRIGHTNESS, 12'hF00);
    add_config(REG_CONTRAST, 12'd4095);
    add_config(REG_SATURATION, 12'd4095);
    add_pixel(8'd255, 8'd255, 8'd255, 8'd7, 1'b0, 0);
    add_pixel(8'd255, 8'd0, 8'd128, 8'd9, 1'b1, 0);
    add_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 0);
    add_pixel(8'd200, 8'd100, 8'd50, 8'd33, 1'b0, 2);
    // brightest offset, zero gains: everything collapses to mid level
    add_config(REG_BRIGHTNESS, 12'd255);
    add_config(REG_CONTRAST, 12'd0);
    add_config(REG_SATURATION, 12'd0);
    add_pixel(8'd0, 8'd255, 8'd17, 8'd200, 1'b1, 0);
    add_pixel(8'd255, 8'd255, 8'd255, 8'd99, 1'b0, 0);
    // unity contrast with saturation off gives plain gray from luma
    add_config(REG_CONTRAST, 12'd256);
    add_config(REG_SPARE, 12'hFFF);
    add_pixel(8'd255, 8'd0, 8'd0, 8'd1, 1'b0, 0);
    add_pixel(8'd0, 8'd255, 8'd0, 8'd2, 1'b0, 0);
    add_pixel(8'd0, 8'd0, 8'd255, 8'd3, 1'b1, 0);
    add_pixel(8'd255, 8'd255, 8'd255, 8'd4, 1'b0, 0);
    // negative offset with strong saturation pushes channels below zero
    add_config(REG_BRIGHTNESS, 12'h1C0);
    add_config(REG_SATURATION, 12'd2048);
    add_pixel(8'd255, 8'd0, 8'd0, 8'd5, 1'b0, 0);
    add_pixel(8'd10, 8'd250, 8'd90, 8'd6, 1'b1, 0);
    add_drain();

    for (int phase = 0; phase < 12; phase++) begin
      add_config(REG_BRIGHTNESS, ($urandom_range(0, 3) == 0)
                 ? (($urandom_range(0, 1) != 0) ? 12'hF00 : 12'h0FF)
                 : 12'($urandom_range(0, 4095)));
      add_config(REG_CONTRAST, rand_gain());
      add_config(REG_SATURATION, rand_gain());
      if ($urandom_range(0, 3) == 0) add_config(REG_SPARE, 12'($urandom_range(0, 4095)));
      gap_style = $urandom_range(0, 2);
      for (int n = 0; n < 75; n++) begin
        case (gap_style)
          0:       gap = 0;
          1:       gap = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(0, 16);
          default: gap = $urandom_range(0, 16);
        endcase
        r = rand_level();
        if ($urandom_range(0, 7) == 0) begin
          g = r;
          b = r;
        end else begin
          g = rand_level();
          b = rand_level();
        end
        add_pixel(r, g, b, pix_t'($urandom_range(0, 255)), ($urandom_range(0, 9) == 0), gap);
        if (n == 40 && phase % 3 == 1) add_drain();
      end
    end

    wait (rst_ni === 1'b1);
    while (pending_ops.size() > 0 || start || beats_sent != results_seen) begin
      @(posedge clk_i);
    end
    repeat (FLUSH_CYCLES) @(posedge clk_i);
    if (expected_pixels.size() != 0) begin
      report_mismatch("outstanding pixels", expected_pixels.size(), 0);
    end
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : reset_proc
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

endmodule
`default_nettype wire
